/* rtl/core/sitda_pkg.sv */
// shared constants and controller/datapath types for the integer to decimal text block
package sitda_pkg;

  localparam int VALUE_BITS = 32;
  // digit count of the largest magnitude, 2^(VALUE_BITS-1)
  localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS = DIGITS * 4;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DIG_W = $clog2(DIGITS + 1);

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO = 6'd48;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ = 4'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic sel_sign;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic last_digit;
    logic neg;
    logic digit_zero;
    logic started;
  } dp_stat_t;

endpackage

/* rtl/core/sitda_dp.sv */
// datapath: magnitude, shift-and-add-3 converter and digit output
module sitda_dp
  import sitda_pkg::*;
(
  input  logic                         clk,
  input  dp_cmd_t                      cmd,
  input  logic signed [VALUE_BITS-1:0] value,
  output dp_stat_t                     stat,
  output logic [5:0]                   character,
  output logic                         last
);

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_BITS-1:0]   bcd;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [CNT_W-1:0]      bit_cnt;
  logic [DIG_W-1:0]      dig_cnt;
  logic                  neg;
  logic                  started;
  logic [3:0]            top_digit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + BCD_ADJ;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[VALUE_BITS-1];
      mag     <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      bcd     <= '0;
      bit_cnt <= CNT_W'(VALUE_BITS - 1);
      dig_cnt <= DIG_W'(DIGITS - 1);
      started <= 1'b0;
    end else if (cmd.step) begin
      {bcd, mag} <= {bcd_adj, mag} << 1;
      bit_cnt    <= bit_cnt - 1'b1;
    end else if (cmd.advance) begin
      bcd     <= bcd << 4;
      dig_cnt <= dig_cnt - 1'b1;
      started <= started | (top_digit != 4'd0);
    end
  end

  assign top_digit = bcd[BCD_BITS-1 -: 4];

  assign stat.conv_done  = (bit_cnt == '0);
  assign stat.last_digit = (dig_cnt == '0);
  assign stat.neg        = neg;
  assign stat.digit_zero = (top_digit == 4'd0);
  assign stat.started    = started;

  assign character = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + {2'b00, top_digit});
  assign last      = ~cmd.sel_sign & (dig_cnt == '0);

endmodule

/* rtl/core/sitda_ctrl.sv */
// controller: sequences load, conversion, sign and digit output
module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE = 4'b0001,
    CONV = 4'b0010,
    SIGN = 4'b0100,
    EMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   show;

  // leading zeros are skipped, but the units digit always shows
  assign show = stat.started | ~stat.digit_zero | stat.last_digit;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CONV;
        end
      end
      CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_done) begin
          state_next = stat.neg ? SIGN : EMIT;
        end
      end
      SIGN: begin
        cmd.sel_sign = 1'b1;
        out_valid    = 1'b1;
        if (out_ready) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        out_valid = show;
        if (~show | out_ready) begin
          cmd.advance = 1'b1;
          if (stat.last_digit) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/signed_int_to_decimal_ascii_top.sv */
// top level of the signed integer to decimal ascii converter
// Converts one signed VALUE_BITS integer per request into its decimal text, one ascii
// character per output request, most significant first, with a leading minus for negative
// values and last set on the final digit. One item at a time: the accept, then the
// shift-and-add-3 converter over all VALUE_BITS bits, then the sign if negative, then a
// scan over the DIGITS positions that skips leading zeros and sends each character,
// stalling while out_ready is low. in_ready is high only between items.
module signed_int_to_decimal_ascii_top
  import sitda_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   character,
  output logic                         last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sitda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sitda_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .value     (value),
    .stat      (stat),
    .character (character),
    .last      (last)
  );

endmodule
